[hdl/smss_pkg.sv]
// Shared types, constants and address helpers for the sorted-matrix staircase search.
// Used by smss_store and sorted_matrix_staircase_search_top; depends on nothing else.
`default_nettype none

package smss_pkg;

   // Matrix bounds
   localparam int unsigned MAX_ROWS = 64;
   localparam int unsigned MAX_COLS = 64;

   // Fixed field widths
   localparam int unsigned ROW_IDX_W = 6;
   localparam int unsigned COL_IDX_W = 6;
   localparam int unsigned DIM_W     = 7;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // Derived storage geometry
   localparam int unsigned DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int unsigned COL_CNT_W = $clog2(MAX_COLS + 1);
   localparam int unsigned FULL_W    = ROW_CNT_W + COL_CNT_W + 1;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_idx_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // Write port of the element store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   // Flat address of (row, col): row * MAX_COLS + col
   function automatic logic [ADDR_W-1:0] elem_addr(
      input logic [ROW_CNT_W-1:0] row,
      input logic [COL_CNT_W-1:0] col
   );
      logic [FULL_W-1:0] full;
      full = FULL_W'(row) * FULL_W'(MAX_COLS) + FULL_W'(col);
      return full[ADDR_W-1:0];
   endfunction

   // Saturate a configured row count to the matrix bound
   function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [DIM_W-1:0] v);
      logic [ROW_CNT_W-1:0] res;
      if (int'(v) > int'(MAX_ROWS)) begin
         res = ROW_CNT_W'(MAX_ROWS);
      end else begin
         res = ROW_CNT_W'(v);
      end
      return res;
   endfunction

   // Saturate a configured column count to the matrix bound
   function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [DIM_W-1:0] v);
      logic [COL_CNT_W-1:0] res;
      if (int'(v) > int'(MAX_COLS)) begin
         res = COL_CNT_W'(MAX_COLS);
      end else begin
         res = COL_CNT_W'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/smss_store.sv]
// Element store: one write port, one registered read port, read every cycle.
// Depends on smss_pkg for geometry and the write-port struct.
`default_nettype none

module smss_store (
   input  wire logic                        clock,
   input  wire smss_pkg::store_wr_type      wr,
   input  wire logic [smss_pkg::ADDR_W-1:0] rd_addr,
   output logic      [smss_pkg::DATA_W-1:0] rd_data
);
   import smss_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one element on a load
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/sorted_matrix_staircase_search_top.sv]
// Load word: writes one element, no result. Query word: accepted, then walked step by
// step, at most rows + cols - 1 steps (127 for a 64x64 matrix); found shows in rsp_found
// the cycle after the deciding compare. Each step is one read of the single store port.
// An empty matrix raises rsp_valid the cycle after its accept. The block takes one word at a time.
// Synchronous active-high reset clears state, result valid and dimension registers;
// the element store is not cleared and holds garbage until loaded.
`default_nettype none

module sorted_matrix_staircase_search_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_op,
   input  wire logic [smss_pkg::ROW_IDX_W-1:0] req_row_index,
   input  wire logic [smss_pkg::COL_IDX_W-1:0] req_col_index,
   input  wire logic signed [smss_pkg::DATA_W-1:0] req_element_value,
   input  wire logic signed [smss_pkg::DATA_W-1:0] req_target_value,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_found,
   // configuration channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [smss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [smss_pkg::DIM_W-1:0]     csr_wdata
);
   import smss_pkg::*;

   state_type                state_ff, state_in;
   logic [DIM_W-1:0]         rows_cfg_ff, cols_cfg_ff;
   logic [ROW_CNT_W-1:0]     r_ff, r_in;
   logic [COL_CNT_W-1:0]     c_ff, c_in;
   logic [COL_CNT_W-1:0]     cols_lim_ff, cols_lim_in;
   logic signed [DATA_W-1:0] target_ff, target_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;

   logic                     req_accept;
   logic                     csr_accept;
   logic [ROW_CNT_W-1:0]     rows_q;
   logic [COL_CNT_W-1:0]     cols_q;
   logic signed [DATA_W-1:0] elem;
   logic [DATA_W-1:0]        rd_data;
   logic [ADDR_W-1:0]        rd_addr;
   store_wr_type             wr;

   // Handshakes
   assign req_ready  = (state_ff == ST_IDLE) &&
                       ((req_op == OP_LOAD) || !rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign rows_q = clamp_rows(rows_cfg_ff);
   assign cols_q = clamp_cols(cols_cfg_ff);
   assign elem   = $signed(rd_data);

   // Element store
   smss_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= '0;
         cols_cfg_ff <= '0;
      end else if (csr_accept) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ROWS: rows_cfg_ff <= csr_wdata;
            CSR_COLS: cols_cfg_ff <= csr_wdata;
            default:  ;
         endcase
      end
   end

   // Sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk position, limits, target and found flag
   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      c_ff         <= c_in;
      cols_lim_ff  <= cols_lim_in;
      target_ff    <= target_in;
      rsp_found_ff <= rsp_found_in;
   end

   // Next state, walk step and store control
   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      cols_lim_in  = cols_lim_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      wr.en        = 1'b0;
      wr.addr      = elem_addr(ROW_CNT_W'(req_row_index), COL_CNT_W'(req_col_index));
      wr.data      = req_element_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_op == OP_LOAD) begin
                  // drop loads outside the matrix bounds
                  wr.en = (int'(req_row_index) < int'(MAX_ROWS)) &&
                          (int'(req_col_index) < int'(MAX_COLS));
               end else if ((rows_q == '0) || (cols_q == '0)) begin
                  // empty matrix: answer at once
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
               end else begin
                  // start at the bottom-left element
                  r_in        = rows_q;
                  c_in        = '0;
                  cols_lim_in = cols_q;
                  target_in   = req_target_value;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            priority if (elem == target_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (elem > target_ff) begin
               // move up a row
               r_in = r_ff - 1'b1;
               if (r_in == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               // move right a column
               c_in = c_ff + 1'b1;
               if (c_in == cols_lim_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Fetch the element at the next position
      rd_addr = elem_addr(r_in - 1'b1, c_in);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   // Position stays inside the matrix while walking
   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((r_ff != '0) && (c_ff < cols_lim_ff)))
      else $error("walk position left the matrix");

   // No result is pending while a walk is running
   a_walk_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !rsp_valid_ff)
      else $error("result slot busy during walk");

   // A new result comes only from a walk end or an empty-matrix query
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
      ($past(state_ff == ST_WALK) || $past(req_accept && (req_op == OP_QUERY))))
      else $error("result without a query");

   // Requests are blocked during a walk
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !req_ready)
      else $error("request accepted during walk");

endmodule

`default_nettype wire
